/* rtl/core/rbd_pkg.sv */
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types, widths and helpers of the 2x2 rgba box downsampler.
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int CHAN_W      = 8;
  localparam int NUM_CHAN    = 4;
  localparam int PIX_W       = CHAN_W * NUM_CHAN;
  localparam int PSUM_W      = CHAN_W + 1;
  localparam int PAIRS_W     = PSUM_W * NUM_CHAN;
  localparam int COORD_W     = 11;
  localparam int CFG_W       = 13;
  localparam int CFG_ADDR_W  = 1;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 56;
  localparam int OUT_USED_W  = PIX_W + 2 * COORD_W;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int SRC_DIM_RESET  = 256;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SRC_WIDTH  = 1'b0,
    REG_SRC_HEIGHT = 1'b1
  } cfg_reg_t;

  // position flags of the pixel about to be taken
  typedef struct packed {
    logic odd_col;
    logic odd_row;
    logic last;
  } pos_t;

  // register value clamped to 1..maxv
  function automatic int clamp_dim(logic [CFG_W-1:0] v, int maxv);
    int r;
    r = int'(v);
    if (r < 1) begin
      r = 1;
    end else if (r > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

  // min width 2 so that the half-position select is never empty
  function automatic int cnt_width(int maxv);
    int r;
    r = $clog2(maxv);
    if (r < 2) begin
      r = 2;
    end
    return r;
  endfunction

endpackage

/* rtl/core/rbd_ctrl.sv */
// ----------------------------------------------------------------------------
// rbd_ctrl
// Dimension registers and raster position counters of the source level.
// ----------------------------------------------------------------------------
module rbd_ctrl import rbd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int CW        = cnt_width(MAX_WIDTH),
  localparam int RW        = cnt_width(MAX_HEIGHT)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wen,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  adv,
  output logic [CW-2:0]         ocol,
  output logic [RW-2:0]         orow,
  output pos_t                  pos
);

  localparam int W_RST = clamp_dim(CFG_W'(SRC_DIM_RESET), MAX_WIDTH);
  localparam int H_RST = clamp_dim(CFG_W'(SRC_DIM_RESET), MAX_HEIGHT);

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] wm1_r, wm1_nxt;
  logic [RW-1:0] hm1_r, hm1_nxt;
  logic [CW-2:0] lastc_r, lastc_nxt;
  logic [RW-2:0] lastr_r, lastr_nxt;
  int            dim;

  assign ocol        = col_r[CW-1:1];
  assign orow        = row_r[RW-1:1];
  assign pos.odd_col = col_r[0];
  assign pos.odd_row = row_r[0];
  assign pos.last    = (ocol == lastc_r) && (orow == lastr_r);

  always_comb begin
    wm1_nxt   = wm1_r;
    hm1_nxt   = hm1_r;
    lastc_nxt = lastc_r;
    lastr_nxt = lastr_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    dim       = 0;
    if (cfg_wen) begin
      // any write restarts the level
      col_nxt = '0;
      row_nxt = '0;
      case (cfg_reg_t'(cfg_addr))
        REG_SRC_WIDTH: begin
          dim       = clamp_dim(cfg_wdata, MAX_WIDTH);
          wm1_nxt   = CW'(dim - 1);
          lastc_nxt = (CW-1)'((dim >> 1) - 1);
        end
        REG_SRC_HEIGHT: begin
          dim       = clamp_dim(cfg_wdata, MAX_HEIGHT);
          hm1_nxt   = RW'(dim - 1);
          lastr_nxt = (RW-1)'((dim >> 1) - 1);
        end
        default: begin
          dim = 0;
        end
      endcase
    end else if (adv) begin
      if (col_r == wm1_r) begin
        col_nxt = '0;
        row_nxt = (row_r == hm1_r) ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      wm1_r   <= CW'(W_RST - 1);
      hm1_r   <= RW'(H_RST - 1);
      lastc_r <= (CW-1)'((W_RST >> 1) - 1);
      lastr_r <= (RW-1)'((H_RST >> 1) - 1);
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      wm1_r   <= wm1_nxt;
      hm1_r   <= hm1_nxt;
      lastc_r <= lastc_nxt;
      lastr_r <= lastr_nxt;
    end
  end

endmodule

/* rtl/core/rbd_linebuf.sv */
// ----------------------------------------------------------------------------
// rbd_linebuf
// Line buffer of per-column pair sums from the last even source row.
// ----------------------------------------------------------------------------
module rbd_linebuf import rbd_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WIDTH / 2,
  parameter int AW    = 11
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic               rd_en,
  input  logic [AW-1:0]      addr,
  input  logic [PAIRS_W-1:0] wdata,
  output logic [PAIRS_W-1:0] rdata_r
);

  logic [PAIRS_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

endmodule

/* rtl/core/rgba_box_downsample_2x2.sv */
// ----------------------------------------------------------------------------
// rgba_box_downsample_2x2
// 2x2 box filter that reduces one rgba8 level to the next mip level.
//
//   channel | dir | tdata (low bit up)             | other
//   --------+-----+--------------------------------+------------------
//   in_     | in  | chan0 chan1 chan2 chan3        | -
//   out_    | out | avg0..avg3 out_col out_row pad | tlast=level_done
//   cfg_    | in  | wen, addr 0 width / 1 height   | 13-bit wdata
//
// one pixel per clock while in_tready is high; a result passes through the
// line buffer read stage, then the add and shift into the output register.
// rst_n is synchronous; it sets a 256x256 level and the start position.
// a held result does not block input; only a pixel that makes a result
// waits while both the read stage and the output register are full.
// ----------------------------------------------------------------------------
module rgba_box_downsample_2x2 import rbd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // chan0, chan1, chan2, chan3
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // avg0..avg3, out_col, out_row, zero pad
  output logic                  out_tlast,
  input  logic                  cfg_wen,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int CW = cnt_width(MAX_WIDTH);
  localparam int RW = cnt_width(MAX_HEIGHT);

  logic [CW-2:0]      ocol;
  logic [RW-2:0]      orow;
  pos_t               pos;
  logic               in_acc;
  logic               produce;
  logic [PAIRS_W-1:0] pairs;
  logic [PIX_W-1:0]   hold_r;
  logic [PAIRS_W-1:0] upper;

  logic               s1_valid_r;
  logic [PAIRS_W-1:0] s1_pairs_r;
  logic [CW-2:0]      s1_ocol_r;
  logic [RW-2:0]      s1_orow_r;
  logic               s1_last_r;
  logic               s1_load;
  logic               s1_free;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_last_r;
  logic                  out_load;

  rbd_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wen  (cfg_wen),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .adv      (in_acc),
    .ocol     (ocol),
    .orow     (orow),
    .pos      (pos)
  );

  rbd_linebuf #(
    .DEPTH(MAX_WIDTH / 2),
    .AW   (CW - 1)
  ) u_linebuf (
    .clk    (clk),
    .wr_en  (in_acc && pos.odd_col && !pos.odd_row),
    .rd_en  (s1_load),
    .addr   (ocol),
    .wdata  (pairs),
    .rdata_r(upper)
  );

  assign produce   = pos.odd_col && pos.odd_row;
  assign out_load  = s1_valid_r && (!out_valid_r || out_tready);
  assign s1_free   = !s1_valid_r || out_load;
  assign in_tready = s1_free || !produce;
  assign in_acc    = in_tvalid && in_tready;
  assign s1_load   = in_acc && produce;

  // horizontal pair sums: held left pixel plus the incoming right pixel
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      pairs[c*PSUM_W +: PSUM_W] = {1'b0, hold_r[c*CHAN_W +: CHAN_W]}
                                + {1'b0, in_tdata[c*CHAN_W +: CHAN_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !pos.odd_col) begin
      hold_r <= in_tdata[PIX_W-1:0];
    end
  end

  // upper pair sums plus lower pair sums, divided by four
  always_comb begin
    out_data_nxt = '0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      out_data_nxt[c*CHAN_W +: CHAN_W] = CHAN_W'(
        10'({1'b0, upper[c*PSUM_W +: PSUM_W]} + {1'b0, s1_pairs_r[c*PSUM_W +: PSUM_W]})
        >> 2);
    end
    out_data_nxt[PIX_W +: COORD_W]           = COORD_W'(s1_ocol_r);
    out_data_nxt[PIX_W + COORD_W +: COORD_W] = COORD_W'(s1_orow_r);
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_pairs_r <= pairs;
      s1_ocol_r  <= ocol;
      s1_orow_r  <= orow;
      s1_last_r  <= pos.last;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
      out_last_r <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (out_load) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r[OUT_DATA_W-1:OUT_USED_W] & '0,
                       out_data_r[OUT_USED_W-1:0]};
  assign out_tlast  = out_last_r;

endmodule

/* rtl/core/rbd_checker.sv */
// ----------------------------------------------------------------------------
// rbd_checker
// Port-level checks of the 2x2 rgba box downsampler, bound to the top level.
// ----------------------------------------------------------------------------
module rbd_checker import rbd_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a held result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // nothing is offered right after reset
  a_rst_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result offered after reset");

  // a fresh result comes from a source pixel taken before it
  a_rose_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a source pixel");

endmodule

bind rgba_box_downsample_2x2 rbd_checker u_rbd_checker (.*);
